// File: hw/rtl/rws_pkg.sv
// Shared types, constants and codes of the roulette wheel selector.
`default_nettype none
package rws_pkg;

  // Defaults for the top level parameters.
  localparam int MAX_POPULATION_DEF = 256;
  localparam int FITNESS_WIDTH_DEF  = 32;

  // Fixed field widths.
  localparam int SLOT_W     = 8;
  localparam int RAND_W     = 32;
  localparam int BIT_W      = $clog2(RAND_W);
  localparam int SEL_W      = 8;
  localparam int TOTAL_W    = 40;
  localparam int STATUS_W   = 2;
  localparam int POP_W      = 9;
  localparam int OUT_DATA_W = ((SEL_W + TOTAL_W + STATUS_W + 7) / 8) * 8;

  localparam logic [POP_W-1:0] POP_RESET = 9'd256;

  // Operation codes carried in the input tuser.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SLOT     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POSITIVE = 2'd2;

  // Operations of the shared adder unit.
  typedef enum logic [1:0] {
    DP_HOLD,
    DP_CLEAR,
    DP_ACC,
    DP_MUL
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load_r;
    logic   keep_tot;
    logic   keep_tgt;
  } dp_ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/roulette_wheel_selector_unit.sv
// Top level of the roulette wheel selector: sequencer, weight store and output register.
//
//  Channel   Direction  Contents
//  s_axis    in         tuser: operation; tdata: slot, fitness, random_fraction
//  m_axis    out        tdata: selected_index, total_weight, status
//  cfg       in         data: population_size
//
// A load and a draw each take one pass over the active population in the weight
// store for the total; a draw then takes 32 shift-add steps on the shared adder
// for the scaled target, then a prefix walk that stops at the hit.
// After reset the store is cleared at one entry a cycle, all MAX_POPULATION entries,
// while no item is taken; configuration writes are taken at any time.
// One item is worked on at a time; a finished result waits in the output register.
`default_nettype none
module roulette_wheel_selector_unit #(
  parameter int MAX_POPULATION = rws_pkg::MAX_POPULATION_DEF,
  parameter int FITNESS_WIDTH  = rws_pkg::FITNESS_WIDTH_DEF,
  localparam int IN_DATA_W =
    ((rws_pkg::SLOT_W + FITNESS_WIDTH + rws_pkg::RAND_W + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [7:0] slot, then fitness, then random_fraction, zero padded
  input  wire logic [IN_DATA_W-1:0]              s_axis_tdata,
  // [0] operation
  input  wire logic [0:0]                        s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [7:0] selected_index, [47:8] total_weight, [49:48] status, zero padded
  output logic [rws_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [rws_pkg::POP_W-1:0]         cfg_data_i
);

  localparam int AW = $clog2(MAX_POPULATION);
  localparam int NW = $clog2(MAX_POPULATION + 1);
  localparam int SW = FITNESS_WIDTH + $clog2(MAX_POPULATION);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_TGT   = 3'd4;
  localparam logic [2:0] S_WALK  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                      state_q, state_d;
  logic [NW-1:0]                   idx_q, idx_d;
  logic [NW-1:0]                   pos_q, pos_d;
  logic [NW-1:0]                   n_q, n_d;
  logic [rws_pkg::BIT_W-1:0]       bit_q, bit_d;
  logic                            vld_q, vld_d;
  logic                            op_q, op_d;
  logic [NW-1:0]                   sel_q, sel_d;
  logic [rws_pkg::STATUS_W-1:0]    st_q, st_d;
  logic [rws_pkg::POP_W-1:0]       pop_q;

  logic                            m_valid_q;
  logic [rws_pkg::SEL_W-1:0]       out_sel_q;
  logic [rws_pkg::TOTAL_W-1:0]     out_tot_q;
  logic [rws_pkg::STATUS_W-1:0]    out_st_q;
  logic                            out_load;

  logic [rws_pkg::SLOT_W-1:0]      in_slot;
  logic [FITNESS_WIDTH-1:0]        in_fit;
  logic [rws_pkg::RAND_W-1:0]      in_rand;
  logic                            in_neg;
  logic [FITNESS_WIDTH-1:0]        in_weight;
  logic [NW-1:0]                   n_act;
  logic                            s_accept;
  logic                            issue;

  logic                            we;
  logic [AW-1:0]                   waddr;
  logic [FITNESS_WIDTH-1:0]        wdata;
  logic [AW-1:0]                   raddr;
  logic [FITNESS_WIDTH-1:0]        rdata;

  rws_pkg::dp_ctrl_t               ctrl;
  logic                            hit;
  logic [SW-1:0]                   total;

  assign in_slot   = s_axis_tdata[rws_pkg::SLOT_W-1:0];
  assign in_fit    = s_axis_tdata[rws_pkg::SLOT_W +: FITNESS_WIDTH];
  assign in_rand   = s_axis_tdata[rws_pkg::SLOT_W + FITNESS_WIDTH +: rws_pkg::RAND_W];
  assign in_neg    = in_fit[FITNESS_WIDTH-1];
  assign in_weight = in_neg ? FITNESS_WIDTH'(~in_fit + FITNESS_WIDTH'(1)) : '0;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign issue         = idx_q < n_q;

  // Population size zero counts as one; sizes above the store saturate.
  always_comb begin
    if (pop_q == '0) begin
      n_act = NW'(1);
    end else if (32'(pop_q) > MAX_POPULATION) begin
      n_act = NW'(MAX_POPULATION);
    end else begin
      n_act = NW'(pop_q);
    end
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    n_d      = n_q;
    bit_d    = bit_q;
    vld_d    = 1'b0;
    op_d     = op_q;
    sel_d    = sel_q;
    st_d     = st_q;
    ctrl     = '{op: rws_pkg::DP_HOLD, load_r: 1'b0, keep_tot: 1'b0, keep_tgt: 1'b0};
    we       = 1'b0;
    waddr    = idx_q[AW-1:0];
    wdata    = '0;
    raddr    = idx_q[AW-1:0];
    out_load = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        if (idx_q[AW-1:0] == AW'(MAX_POPULATION - 1)) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + NW'(1);
        end
      end
      S_IDLE: begin
        if (s_accept) begin
          n_d         = n_act;
          op_d        = s_axis_tuser[0];
          idx_d       = '0;
          pos_d       = '0;
          sel_d       = '0;
          ctrl.op     = rws_pkg::DP_CLEAR;
          ctrl.load_r = 1'b1;
          st_d        = rws_pkg::ST_OK;
          if (s_axis_tuser[0] == rws_pkg::OP_LOAD) begin
            we    = 32'(in_slot) < MAX_POPULATION;
            waddr = AW'(in_slot);
            wdata = in_weight;
            if (32'(in_slot) >= 32'(n_act)) begin
              st_d = rws_pkg::ST_SLOT;
            end else if (!in_neg && (in_fit != '0)) begin
              st_d = rws_pkg::ST_POSITIVE;
            end
          end
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        vld_d = issue;
        idx_d = idx_q + NW'(issue);
        if (vld_q) begin
          ctrl.op = rws_pkg::DP_ACC;
        end
        if (!issue && !vld_q) begin
          ctrl.keep_tot = 1'b1;
          ctrl.op       = rws_pkg::DP_CLEAR;
          bit_d         = '0;
          state_d       = (op_q == rws_pkg::OP_LOAD) ? S_DONE : S_SCALE;
        end
      end
      S_SCALE: begin
        ctrl.op = rws_pkg::DP_MUL;
        bit_d   = bit_q + rws_pkg::BIT_W'(1);
        if (bit_q == rws_pkg::BIT_W'(rws_pkg::RAND_W - 1)) begin
          state_d = S_TGT;
        end
      end
      S_TGT: begin
        ctrl.keep_tgt = 1'b1;
        ctrl.op       = rws_pkg::DP_CLEAR;
        idx_d         = '0;
        pos_d         = '0;
        state_d       = S_WALK;
      end
      S_WALK: begin
        vld_d = issue;
        idx_d = idx_q + NW'(issue);
        if (vld_q) begin
          ctrl.op = rws_pkg::DP_ACC;
          pos_d   = pos_q + NW'(1);
          if (hit || (pos_q == n_q - NW'(1))) begin
            sel_d   = pos_q;
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      idx_q     <= '0;
      pos_q     <= '0;
      n_q       <= '0;
      bit_q     <= '0;
      vld_q     <= 1'b0;
      op_q      <= rws_pkg::OP_LOAD;
      pop_q     <= rws_pkg::POP_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pos_q   <= pos_d;
      n_q     <= n_d;
      bit_q   <= bit_d;
      vld_q   <= vld_d;
      op_q    <= op_d;
      if (cfg_valid_i && cfg_ready_o) begin
        pop_q <= cfg_data_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;
    st_q  <= st_d;
    if (out_load) begin
      out_sel_q <= rws_pkg::SEL_W'(sel_q);
      out_tot_q <= rws_pkg::TOTAL_W'(total);
      out_st_q  <= st_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = rws_pkg::OUT_DATA_W'({out_st_q, out_tot_q, out_sel_q});

  rws_ram #(
    .WIDTH (FITNESS_WIDTH),
    .DEPTH (MAX_POPULATION)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rws_dpath #(
    .FW (FITNESS_WIDTH),
    .SW (SW)
  ) u_dpath (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .rand_i  (in_rand),
    .rdata_i (rdata),
    .hit_o   (hit),
    .total_o (total)
  );

`ifndef SYNTHESIS
  a_no_take_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready)
    else $error("input taken during the store clearing pass");

  a_sel_in_population: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (32'(sel_q) < 32'(n_q)))
    else $error("selected index outside the active population");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_DONE))
    else $error("result presented without a finished item");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/rws_ram.sv
// Generic simple dual port RAM with registered read.
`default_nettype none
module rws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: hw/rtl/rws_dpath.sv
// Shared adder unit: weight sums, shift-add scaling and the prefix walk.
`default_nettype none
module rws_dpath #(
  parameter int FW = 32,
  parameter int SW = 40
) (
  input  wire logic                      clk_i,
  input  wire rws_pkg::dp_ctrl_t         ctrl_i,
  input  wire logic [rws_pkg::RAND_W-1:0] rand_i,
  input  wire logic [FW-1:0]             rdata_i,
  output logic                           hit_o,
  output logic      [SW-1:0]             total_o
);

  logic [SW:0]                 acc_q, acc_d;
  logic [SW-1:0]               tot_q, tgt_q;
  logic [rws_pkg::RAND_W-1:0]  r_q, r_d;
  logic [SW:0]                 add_b;
  logic [SW:0]                 sum;

  // One adder serves every phase; only its second operand changes.
  always_comb begin
    if (ctrl_i.op == rws_pkg::DP_MUL) begin
      add_b = r_q[0] ? {1'b0, tot_q} : '0;
    end else begin
      add_b = (SW + 1)'(rdata_i);
    end
    sum   = acc_q + add_b;
    hit_o = sum >= {1'b0, tgt_q};
  end

  always_comb begin
    acc_d = acc_q;
    r_d   = ctrl_i.load_r ? rand_i : r_q;
    unique case (ctrl_i.op)
      rws_pkg::DP_HOLD:  acc_d = acc_q;
      rws_pkg::DP_CLEAR: acc_d = '0;
      rws_pkg::DP_ACC:   acc_d = sum;
      rws_pkg::DP_MUL: begin
        // Least significant bit first; the dropped bits give the floor.
        acc_d = sum >> 1;
        r_d   = r_q >> 1;
      end
      default:           acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    r_q   <= r_d;
    if (ctrl_i.keep_tot) begin
      tot_q <= acc_q[SW-1:0];
    end
    if (ctrl_i.keep_tgt) begin
      tgt_q <= acc_q[SW-1:0];
    end
  end

  assign total_o = tot_q;

endmodule
`default_nettype wire
